// ----- rtl/core/osar_pkg.sv -----
package osar_pkg;

  // table geometry
  localparam int ROWS    = 64;
  localparam int COORD_W = 10;
  localparam int CNT_W   = $clog2(ROWS + 1);

  // stream word widths
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_SCAN,
    S_MISS
  } state_t;

  // one sweep event
  typedef struct packed {
    coord_t seg_end_y;
    coord_t seg_end_x;
    coord_t seg_start_y;
    coord_t seg_start_x;
    coord_t event_x;
  } item_t;

  // one result word
  typedef struct packed {
    logic    hit_valid;
    coord_t  hit_x;
    coord_t  hit_y;
    status_t status;
    logic    last;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture event and latch compare vectors
    logic apply;     // commit insert or remove
    logic rotate;    // rotate active slots by one during a query
    logic emit;      // load output register
    logic emit_hit;  // output word carries the head slot as a hit
  } rows_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic in_vert;    // incoming event is vertical
    logic cnt_zero;   // no active rows
    logic head_hit;   // head slot lies in the query range
    logic scan_end;   // head slot is the last active slot
    logic hit_seen;   // query has emitted at least one hit
  } rows_sts_t;

endpackage

// ----- rtl/core/osar_ctrl.sv -----
module osar_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  osar_pkg::rows_sts_t sts,
  output osar_pkg::rows_cmd_t cmd
);

  osar_pkg::state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= osar_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      osar_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!sts.in_vert) begin
            state_next = osar_pkg::S_UPD;
          end else if (sts.cnt_zero) begin
            state_next = osar_pkg::S_MISS;
          end else begin
            state_next = osar_pkg::S_SCAN;
          end
        end
      end
      osar_pkg::S_UPD: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          cmd.apply  = 1'b1;
          state_next = osar_pkg::S_IDLE;
        end
      end
      osar_pkg::S_SCAN: begin
        // a hit waits for a free output slot, a miss just rotates past
        if (!sts.head_hit || out_free) begin
          cmd.rotate   = 1'b1;
          cmd.emit     = sts.head_hit;
          cmd.emit_hit = sts.head_hit;
          if (sts.scan_end) begin
            state_next = (sts.hit_seen || sts.head_hit) ? osar_pkg::S_IDLE
                                                        : osar_pkg::S_MISS;
          end
        end
      end
      osar_pkg::S_MISS: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = osar_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = osar_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/osar_rows.sv -----
module osar_rows (
  input  logic                clk,
  input  logic                rst,
  input  osar_pkg::item_t     item,
  input  osar_pkg::rows_cmd_t cmd,
  output osar_pkg::rows_sts_t sts,
  output osar_pkg::result_t   res
);

  localparam int ROWS  = osar_pkg::ROWS;
  localparam int CNT_W = osar_pkg::CNT_W;

  osar_pkg::coord_t keys [ROWS];
  osar_pkg::cnt_t   count;
  osar_pkg::cnt_t   idx;
  logic             hit_seen;

  // captured event
  osar_pkg::coord_t ex, key_y, lo, hi;
  logic             vert, ins;

  // per-slot compares against the incoming key, latched at load
  logic [ROWS-1:0] lt_cmp, eq_cmp;
  logic [ROWS-1:0] lt_r;
  logic            found;

  logic             apply_ok, shift_ins, shift_rem;
  osar_pkg::status_t upd_st;

  // event capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ex    <= item.event_x;
      key_y <= item.seg_start_y;
      vert  <= (item.seg_start_x == item.seg_end_x);
      ins   <= (item.event_x == item.seg_start_x);
      lo    <= (item.seg_start_y < item.seg_end_y) ? item.seg_start_y : item.seg_end_y;
      hi    <= (item.seg_start_y < item.seg_end_y) ? item.seg_end_y : item.seg_start_y;
      lt_r  <= lt_cmp;
      found <= |eq_cmp;
    end
  end

  // status of an insert or remove; ok for a vertical event
  always_comb begin
    if (vert) begin
      upd_st = osar_pkg::ST_OK;
    end else if (ins) begin
      if (found) begin
        upd_st = osar_pkg::ST_DUP;
      end else if (count == CNT_W'(ROWS)) begin
        upd_st = osar_pkg::ST_FULL;
      end else begin
        upd_st = osar_pkg::ST_OK;
      end
    end else begin
      upd_st = found ? osar_pkg::ST_OK : osar_pkg::ST_ABSENT;
    end
  end

  assign apply_ok  = cmd.apply && !vert && (upd_st == osar_pkg::ST_OK);
  assign shift_ins = apply_ok && ins;
  assign shift_rem = apply_ok && !ins;

  // row of slot cells: compare, shift open, shift closed, rotate
  for (genvar i = 0; i < ROWS; i++) begin : g_cell
    osar_pkg::coord_t prev_key, next_key;
    logic             prev_lt;
    logic             active;

    if (i == 0) begin : g_first
      assign prev_key = key_y;
      assign prev_lt  = 1'b1;
    end else begin : g_mid
      assign prev_key = keys[i-1];
      assign prev_lt  = lt_r[i-1];
    end

    if (i == ROWS - 1) begin : g_last
      assign next_key = keys[i];
    end else begin : g_inner
      assign next_key = keys[i+1];
    end

    assign active    = (CNT_W'(i) < count);
    assign lt_cmp[i] = active && (keys[i] < item.seg_start_y);
    assign eq_cmp[i] = active && (keys[i] == item.seg_start_y);

    always_ff @(posedge clk) begin
      if (shift_ins && !lt_r[i]) begin
        keys[i] <= prev_lt ? key_y : prev_key;
      end else if (shift_rem && !lt_r[i]) begin
        keys[i] <= next_key;
      end else if (cmd.rotate) begin
        keys[i] <= (CNT_W'(i) == count - 1'b1) ? keys[0] : next_key;
      end
    end
  end

  // active row count and scan position
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      idx      <= '0;
      hit_seen <= 1'b0;
    end else begin
      if (shift_ins) begin
        count <= count + 1'b1;
      end else if (shift_rem) begin
        count <= count - 1'b1;
      end
      if (cmd.load) begin
        idx      <= '0;
        hit_seen <= 1'b0;
      end else if (cmd.rotate) begin
        idx      <= idx + 1'b1;
        hit_seen <= hit_seen | cmd.emit_hit;
      end
    end
  end

  assign sts.in_vert  = (item.seg_start_x == item.seg_end_x);
  assign sts.cnt_zero = (count == '0);
  assign sts.head_hit = (keys[0] >= lo) && (keys[0] <= hi);
  assign sts.scan_end = (idx == count - 1'b1);
  assign sts.hit_seen = hit_seen;

  // result word
  always_comb begin
    if (cmd.emit_hit) begin
      res.hit_valid = 1'b1;
      res.hit_x     = ex;
      res.hit_y     = keys[0];
      res.status    = osar_pkg::ST_OK;
      res.last      = sts.scan_end || (keys[1] > hi);
    end else begin
      res.hit_valid = 1'b0;
      res.hit_x     = '0;
      res.hit_y     = '0;
      res.status    = upd_st;
      res.last      = 1'b1;
    end
  end

endmodule

// ----- rtl/core/orthogonal_sweep_active_rows.sv -----
// Active-row table for an orthogonal segment intersection sweep.
//
// s_axis carries one sweep event per word, sorted by x. m_axis returns the
// results: one word per intersection for a vertical event, else one status
// word. tlast marks the final word caused by an event.
//
// Sequence: an insert or remove is a capture with a parallel compare of
// all slots, then one shift of the sorted table. A vertical query captures
// the event, then the active slots rotate past the head cell one per cycle
// while no hit waits for a stalled output, so one hit leaves per cycle; a
// query with no hit then emits a status word. A query on an empty table
// emits only its status word after the capture. The first result word
// passes the capture registers and then the output register.
//
// Reset empties the table and drops any pending output word. A stalled
// receiver holds the output register; the block waits with it whenever it
// has a word to emit, and takes no new event until the current one has
// moved all its words into the output register.
module orthogonal_sweep_active_rows (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // event_x, seg_start_x, seg_start_y, seg_end_x, seg_end_y, zero pad
  input  logic [osar_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit_x, hit_y, status, zero pad
  output logic [osar_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // hit_valid
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CW = osar_pkg::COORD_W;

  osar_pkg::item_t     item;
  osar_pkg::rows_cmd_t cmd;
  osar_pkg::rows_sts_t sts;
  osar_pkg::result_t   res;
  osar_pkg::result_t   out_word;
  logic                out_free;

  // unpack input word
  assign item.event_x     = s_axis_tdata[CW-1:0];
  assign item.seg_start_x = s_axis_tdata[2*CW-1:CW];
  assign item.seg_start_y = s_axis_tdata[3*CW-1:2*CW];
  assign item.seg_end_x   = s_axis_tdata[4*CW-1:3*CW];
  assign item.seg_end_y   = s_axis_tdata[5*CW-1:4*CW];

  assign out_free = !m_axis_tvalid || m_axis_tready;

  osar_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  osar_rows u_rows (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .cmd  (cmd),
    .sts  (sts),
    .res  (res)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_word <= res;
    end
  end

  // pack output word
  assign m_axis_tdata = {2'b00, out_word.status, out_word.hit_y, out_word.hit_x};
  assign m_axis_tuser = out_word.hit_valid;
  assign m_axis_tlast = out_word.last;

endmodule

// ----- rtl/core/osar_check.sv -----
module osar_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [osar_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                      m_axis_tuser,
  input logic                            m_axis_tlast
);

  // no output word right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // a stalled output word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
      && $stable(m_axis_tuser))
    else $error("stalled output word changed");

  // one event at a time: no accept in the cycle after an accept
  a_one_event: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("event accepted while busy");

  // a status word is always the last word of its event, with zero point
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |->
      m_axis_tlast && (m_axis_tdata[2*osar_pkg::COORD_W-1:0] == '0))
    else $error("status word malformed");

  // a hit word carries status ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      m_axis_tdata[2*osar_pkg::COORD_W+1:2*osar_pkg::COORD_W] == osar_pkg::ST_OK)
    else $error("hit word with nonzero status");

endmodule

bind orthogonal_sweep_active_rows osar_check u_osar_check (.*);
